>>> hw/rtl/amf_pkg.sv
// Package for the adaptive median filter: sizes, register map, item types,
// state encodings and the small helper used to find the median rank.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package amf_pkg;

  localparam int MAX_WINDOW = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int SPAN    = 2 * (MAX_WINDOW / 2) + 1;
  localparam int PADW    = MAX_WIDTH + SPAN - 1;
  localparam int LS_ROWS = SPAN - 1;
  localparam int NWIN    = SPAN * SPAN;

  localparam int COL_W  = $clog2(PADW);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + SPAN - 1);
  localparam int PW_W   = $clog2(PADW + 1);
  localparam int PH_W   = $clog2(MAX_HEIGHT + SPAN);
  localparam int SPAN_W = $clog2(SPAN + 1);
  localparam int IDX_W  = $clog2(SPAN);
  localparam int ELEM_W = $clog2(NWIN);
  localparam int CNT_W  = $clog2(NWIN + 1);

  localparam int DIM_W  = 11;
  localparam int MW_W   = 3;
  localparam int PIX_W  = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [SPAN_W-1:0] MIN_WINDOW = SPAN_W'(3);
  localparam logic [SPAN_W-1:0] SIDE_STEP  = SPAN_W'(2);

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_WINDOW   = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             frame_end;
  } flt_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SHIFT, ST_START, ST_WAIT, ST_EVAL, ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    SS_IDLE, SS_MIN, SS_MAX, SS_MED
  } stat_state_t;

  typedef struct packed {
    logic              start;
    logic [SPAN_W-1:0] side;
    logic [SPAN_W-1:0] pad;
  } stats_req_t;

  typedef struct packed {
    logic             done;
    logic             rot;
    logic [PIX_W-1:0] mn;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] centre;
  } stats_rsp_t;

  // Zero-based rank of the median in a side x side window.
  function automatic logic [CNT_W-1:0] med_rank(input logic [SPAN_W-1:0] side);
    logic [2*SPAN_W-1:0] sq;
    sq = {{SPAN_W{1'b0}}, side} * {{SPAN_W{1'b0}}, side};
    return CNT_W'((sq - 1'b1) >> 1);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/amf_stats.sv
// Window statistics unit: min, median and max of a centred sub-window,
// found with one shared comparator over a rotating register window.
// Depends on amf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module amf_stats import amf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire stats_req_t req,
  input  wire logic [PIX_W-1:0] elem,
  output stats_rsp_t      rsp
);

  stat_state_t       state, state_next;
  logic [ELEM_W-1:0] step;
  logic [IDX_W-1:0]  row, col;
  logic [2:0]        bitpos;
  logic [PIX_W-1:0]  mn, mx, ans, centre;
  logic [CNT_W-1:0]  cnt, total, rank;
  logic              done;

  logic [SPAN_W-1:0] half, lo, hi, rowx, colx;
  logic [PIX_W-1:0]  cmp_a, cmp_b, trial;
  logic              member, lt, hit, last;

  always_comb begin
    half   = req.side >> 1;
    lo     = req.pad - half;
    hi     = req.pad + half;
    rowx   = SPAN_W'(row);
    colx   = SPAN_W'(col);
    member = (rowx >= lo) && (rowx <= hi) && (colx >= lo) && (colx <= hi);
    trial  = ans | (PIX_W'(1) << bitpos);
    rank   = med_rank(req.side);
    last   = (step == ELEM_W'(NWIN - 1));
    unique case (state)
      SS_MIN: begin
        cmp_a = elem;
        cmp_b = mn;
      end
      SS_MAX: begin
        cmp_a = mx;
        cmp_b = elem;
      end
      default: begin
        cmp_a = elem;
        cmp_b = trial;
      end
    endcase
    lt    = cmp_a < cmp_b;
    hit   = member && lt;
    total = cnt + CNT_W'(hit);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SS_IDLE: if (req.start) state_next = SS_MIN;
      SS_MIN:  if (last) state_next = SS_MAX;
      SS_MAX:  if (last) state_next = SS_MED;
      SS_MED:  if (last && bitpos == 3'd0) state_next = SS_IDLE;
      default: state_next = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == SS_MED) && last && (bitpos == 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == SS_IDLE) begin
      if (req.start) begin
        step   <= '0;
        row    <= '0;
        col    <= '0;
        mn     <= '1;
        mx     <= '0;
        ans    <= '0;
        cnt    <= '0;
        bitpos <= 3'd7;
      end
    end else begin
      step <= last ? '0 : step + 1'b1;
      if (col == IDX_W'(SPAN - 1)) begin
        col <= '0;
        row <= (row == IDX_W'(SPAN - 1)) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
      unique case (state)
        SS_MIN: begin
          if (hit) mn <= elem;
          if (rowx == req.pad && colx == req.pad) centre <= elem;
        end
        SS_MAX: begin
          if (hit) mx <= elem;
        end
        default: begin
          if (last) begin
            if (total <= rank) ans <= trial;
            cnt    <= '0;
            bitpos <= bitpos - 1'b1;
          end else begin
            cnt <= total;
          end
        end
      endcase
    end
  end

  always_comb begin
    rsp.done   = done;
    rsp.rot    = (state != SS_IDLE);
    rsp.mn     = mn;
    rsp.md     = ans;
    rsp.mx     = mx;
    rsp.centre = centre;
  end

endmodule
`default_nettype wire

>>> hw/rtl/adaptive_median_filter_top.sv
// Adaptive median filter top level: configuration registers, line store,
// register window, input sequencer and output register.
// Depends on amf_pkg and amf_stats.
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: an item that gives no result frees the block after the shift
// state. One with a result passes start, wait and evaluate once for each of W
// windows tried (1 to 3), then the output state; each statistics pass
// walks all 49 window registers through the single shared comparator.
// No new item is taken until the last one is through. Synchronous active-high
// reset clears control, counters, window and configuration registers; the line store is not cleared.
module adaptive_median_filter_top import amf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire pix_item_t         pix_item,
  output logic                   flt_valid,
  input  wire logic              flt_ready,
  output flt_item_t              flt_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // Configuration registers, written through the APB port.
  logic [DIM_W-1:0] frame_width, frame_height;
  logic [MW_W-1:0]  max_window;
  logic [1:0]       reg_idx;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(640);
      frame_height <= DIM_W'(480);
      max_window   <= MW_W'(7);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        REG_MAX_WINDOW:   max_window   <= pwdata[MW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
      REG_MAX_WINDOW:   prdata = DATA_W'(max_window);
      default:          prdata = '0;
    endcase
  end

  // Registers are clamped into range, then the padded frame size follows.
  logic [PW_W-1:0]   w_c, pw, twop_w;
  logic [PH_W-1:0]   h_c, ph, twop_h;
  logic [SPAN_W-1:0] mw_c, pad;

  always_comb begin
    if (frame_width == '0) w_c = PW_W'(1);
    else if (32'(frame_width) > 32'(MAX_WIDTH)) w_c = PW_W'(MAX_WIDTH);
    else w_c = PW_W'(frame_width);
    if (frame_height == '0) h_c = PH_W'(1);
    else if (32'(frame_height) > 32'(MAX_HEIGHT)) h_c = PH_W'(MAX_HEIGHT);
    else h_c = PH_W'(frame_height);
    if (SPAN_W'(max_window) < MIN_WINDOW && 32'(max_window) < 32'(MIN_WINDOW)) begin
      mw_c = MIN_WINDOW;
    end else if (32'(max_window) > 32'(MAX_WINDOW)) begin
      mw_c = SPAN_W'(MAX_WINDOW);
    end else begin
      mw_c = SPAN_W'(max_window);
    end
    pad    = mw_c >> 1;
    twop_w = PW_W'(pad) << 1;
    twop_h = PH_W'(pad) << 1;
    pw     = w_c + twop_w;
    ph     = h_c + twop_h;
  end

  // Sequencer state and per-item registers.
  ctl_state_t        state, state_next;
  logic [COL_W-1:0]  col_count, cur_c, c_eff;
  logic [ROW_W-1:0]  row_count, cur_r, r_eff;
  logic [PIX_W-1:0]  cur_px, result;
  logic              cur_end;
  logic [SPAN_W-1:0] side;
  logic              accept, has_result, at_end, last_col, last_row;
  logic              side_done, median_ok, centre_ok, out_load;
  logic [PW_W-1:0]   c_ext;
  logic [PH_W-1:0]   r_ext;
  logic [SPAN_W:0]   side_sum;

  assign accept = pix_valid && pix_ready;
  assign c_eff  = pix_item.frame_start ? '0 : col_count;
  assign r_eff  = pix_item.frame_start ? '0 : row_count;

  // Line store: one word per padded column, holding the earlier rows.
  logic [LS_ROWS*PIX_W-1:0] line_store [PADW];
  logic [LS_ROWS*PIX_W-1:0] ls_rdata;

  always_ff @(posedge clk) begin
    if (accept) ls_rdata <= line_store[c_eff];
    if (state == ST_SHIFT) begin
      line_store[cur_c] <= {ls_rdata[(LS_ROWS-1)*PIX_W-1:0], cur_px};
    end
  end

  // Register window, flattened as row-back * SPAN + column-back. It shifts
  // one column per item and rotates by one entry per statistics step, so a
  // full pass of NWIN steps leaves it where it started.
  stats_req_t       sreq;
  stats_rsp_t       srsp;
  logic [PIX_W-1:0] win [NWIN];
  logic [PIX_W-1:0] col_vec [SPAN];

  always_comb begin
    col_vec[0] = cur_px;
    for (int d = 1; d < SPAN; d++) begin
      col_vec[d] = ls_rdata[(d-1)*PIX_W +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NWIN; e++) win[e] <= '0;
    end else if (state == ST_SHIFT) begin
      for (int d = 0; d < SPAN; d++) begin
        for (int j = SPAN - 1; j > 0; j--) win[d*SPAN+j] <= win[d*SPAN+j-1];
        win[d*SPAN] <= col_vec[d];
      end
    end else if (srsp.rot) begin
      for (int e = 0; e < NWIN - 1; e++) win[e] <= win[e+1];
      win[NWIN-1] <= win[0];
    end
  end

  assign sreq.start = (state == ST_START);
  assign sreq.side  = side;
  assign sreq.pad   = pad;

  amf_stats u_stats (
    .clk  (clk),
    .rst  (rst),
    .req  (sreq),
    .elem (win[0]),
    .rsp  (srsp)
  );

  // Position tests for the current item, against the current registers.
  always_comb begin
    c_ext      = PW_W'(cur_c);
    r_ext      = PH_W'(cur_r);
    has_result = (r_ext >= twop_h) && (c_ext >= twop_w) && (r_ext < ph) && (c_ext < pw);
    at_end     = (r_ext == ph - 1'b1) && (c_ext == pw - 1'b1);
    last_col   = (c_ext + 1'b1) >= pw;
    last_row   = (r_ext + 1'b1) >= ph;
    side_sum   = {1'b0, side} + {1'b0, SIDE_STEP};
    side_done  = side_sum > {1'b0, mw_c};
    median_ok  = (srsp.mn < srsp.md) && (srsp.md < srsp.mx);
    centre_ok  = (srsp.mn < srsp.centre) && (srsp.centre < srsp.mx);
    out_load   = (state == ST_OUT) && (!flt_valid || flt_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (pix_valid) state_next = ST_SHIFT;
      ST_SHIFT: state_next = has_result ? ST_START : ST_IDLE;
      ST_START: state_next = ST_WAIT;
      ST_WAIT:  if (srsp.done) state_next = ST_EVAL;
      ST_EVAL:  state_next = (median_ok || side_done) ? ST_OUT : ST_START;
      ST_OUT:   if (!flt_valid || flt_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign pix_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col_count <= '0;
      row_count <= '0;
      flt_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SHIFT) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : cur_r + 1'b1;
        end else begin
          col_count <= cur_c + 1'b1;
          row_count <= cur_r;
        end
      end
      if (out_load) flt_valid <= 1'b1;
      else if (flt_ready) flt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_c  <= c_eff;
      cur_r  <= r_eff;
      cur_px <= pix_item.pixel;
    end
    if (state == ST_SHIFT) begin
      cur_end <= at_end;
      side    <= MIN_WINDOW;
    end
    if (state == ST_EVAL) begin
      result <= (median_ok && centre_ok) ? srsp.centre : srsp.md;
      if (!median_ok && !side_done) side <= side_sum[SPAN_W-1:0];
    end
    if (out_load) begin
      flt_item.filtered  <= result;
      flt_item.frame_end <= cur_end;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/amf_checker.sv
// Port-level checker for the adaptive median filter, bound to the top level.
// Depends on amf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module amf_checker import amf_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      pix_valid,
  input wire logic      pix_ready,
  input wire logic      flt_valid,
  input wire logic      flt_ready,
  input wire flt_item_t flt_item,
  input wire logic      pready
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> !pix_ready)
    else $error("block ready right after taking an item");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    flt_valid && !flt_ready |=> flt_valid && $stable(flt_item))
    else $error("stalled result changed or dropped");

  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(flt_valid) |-> pix_ready)
    else $error("result shown while block still busy");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !flt_valid && pready)
    else $error("result valid after reset");

endmodule

bind adaptive_median_filter_top amf_checker u_amf_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_valid),
  .pix_ready (pix_ready),
  .flt_valid (flt_valid),
  .flt_ready (flt_ready),
  .flt_item  (flt_item),
  .pready    (pready)
);
`default_nettype wire
